// File: rtl/core/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Shared types and codes for the ordered list store: request and result
// beats, request and status codes, and the control word sent to every cell.
// ----------------------------------------------------------------------------
package ols_pkg;

    // Field widths of the request and result beats
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Request beat
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] word_in;
    } t_in_beat;

    // Result beat
    typedef struct packed {
        logic [DATA_W-1:0]  word_out;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count_now;
    } t_out_beat;

    // Broadcast control for the cell row
    typedef struct packed {
        logic shift_up;   // open a slot at the point and load the new word there
        logic shift_dn;   // close the slot at the point
    } t_cell_ctrl;

endpackage

// File: rtl/core/ols_cell.sv
// ----------------------------------------------------------------------------
// ols_cell
// One list entry. Holds a word, takes its left or right neighbor's word when
// the row shifts, loads the new word at the insertion point, and offers its
// word on the read bus when its index matches the point.
// ----------------------------------------------------------------------------
module ols_cell #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 7,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  ols_pkg::t_cell_ctrl  i_ctrl,
    input  logic [PW-1:0]        i_point,
    input  logic [WORD_BITS-1:0] i_word_new,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    output logic [WORD_BITS-1:0] o_word,
    output logic [WORD_BITS-1:0] o_sel_word
);
    import ols_pkg::*;

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic                 at_point;
    logic                 above_point;

    // Locate this cell against the point
    assign at_point    = (IDX_V == i_point);
    assign above_point = (IDX_V > i_point);

    // Pick the next word
    always_comb begin
        if (i_ctrl.shift_up && at_point) begin
            n_word = i_word_new;
        end else if (i_ctrl.shift_up && above_point) begin
            n_word = i_left;
        end else if (i_ctrl.shift_dn && (at_point || above_point)) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_sel_word = at_point ? r_word : '0;

endmodule

// File: rtl/core/ordered_list_store_top.sv
// ----------------------------------------------------------------------------
// ordered_list_store_top
// Fixed-capacity ordered list of words held in a row of shifting cells.
// Insert, append, remove, read and clear, one request per beat.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+----------------------------------
//   in      | in  | i_in_valid / o_in_stall   | i_in  (req_type, position, word)
//   out     | out | o_out_valid / i_out_stall | o_out (word, status, count)
//
// Each request is decoded and applied to all cells in the cycle it is taken;
// its result sits in the output register from the next cycle. One request per
// cycle is sustained unless stalled; a single cell-row update per cycle sets it.
// Synchronous reset empties the list (count to zero) and drops the result.
// A stalled result holds the input side stalled until it is taken.
// ----------------------------------------------------------------------------
module ordered_list_store_top #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ols_pkg::t_in_beat i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ols_pkg::t_out_beat o_out
);
    import ols_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic                 accept;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    t_out_beat            r_out;
    t_out_beat            n_out;
    t_cell_ctrl           ctrl;
    logic [PW-1:0]        point;
    logic [PW-1:0]        pos_ext;
    logic [PW-1:0]        count_ext;
    logic                 out_of_range;
    logic                 full;
    logic [WORD_BITS-1:0] word_new;
    logic [WORD_BITS-1:0] sel_word;
    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] cell_sel  [CAPACITY];

    // Handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Range and fill checks
    assign pos_ext      = PW'(i_in.position);
    assign count_ext    = PW'(r_count);
    assign out_of_range = (pos_ext >= count_ext);
    assign full         = (r_count == CW'(CAPACITY));
    assign word_new     = WORD_BITS'(i_in.word_in);

    // Append loads at the tail, all others work at the given position
    assign point = (i_in.req_type == REQ_APPEND) ? count_ext : pos_ext;

    // Decode the request into cell control, next count and result
    always_comb begin
        ctrl            = '0;
        n_count         = r_count;
        n_out.word_out  = '0;
        n_out.status    = ST_OK;
        unique case (i_in.req_type)
            REQ_INSERT: begin
                if (out_of_range) begin
                    n_out.status = ST_RANGE;
                end else if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctrl.shift_up = 1'b1;
                    n_count       = r_count + CW'(1);
                end
            end
            REQ_APPEND: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ctrl.shift_up = 1'b1;
                    n_count       = r_count + CW'(1);
                end
            end
            REQ_REMOVE: begin
                if (out_of_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    ctrl.shift_dn  = 1'b1;
                    n_out.word_out = DATA_W'(sel_word);
                    n_count        = r_count - CW'(1);
                end
            end
            REQ_READ: begin
                if (out_of_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.word_out = DATA_W'(sel_word);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            ctrl = '0;
        end
        n_out.count_now = COUNT_W'(n_count);
    end

    // Cell row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] left;
        logic [WORD_BITS-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_word[g+1];
        end

        ols_cell #(
            .WORD_BITS (WORD_BITS),
            .PW        (PW),
            .IDX       (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_point    (point),
            .i_word_new (word_new),
            .i_left     (left),
            .i_right    (right),
            .o_word     (cell_word[g]),
            .o_sel_word (cell_sel[g])
        );
    end

    // Merge the one-hot read bus; at most one cell drives a nonzero word
    always_comb begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            sel_word = sel_word | cell_sel[k];
        end
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/ols_checker.sv
// ----------------------------------------------------------------------------
// ols_checker
// Port-level checks for the ordered list store: result timing, clear and
// read outcomes, and output hold under stall.
// ----------------------------------------------------------------------------
module ols_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ols_pkg::t_in_beat  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ols_pkg::t_out_beat o_out
);
    import ols_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // Every taken request shows its result in the next cycle
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("no result after an accepted request");

    // Clear always empties the list
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.req_type == REQ_CLEAR)
        |=> (o_out.count_now == '0) && (o_out.status == ST_OK))
        else $error("clear did not empty the list");

    // Read and remove never report a full list
    a_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ((i_in.req_type == REQ_READ) || (i_in.req_type == REQ_REMOVE))
        |=> (o_out.status != ST_FULL))
        else $error("full status on read or remove");

    // Stalled result stays valid and unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind ordered_list_store_top ols_checker u_ols_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
